// File: hw/rtl/string_escape_decoder_utf8_assert.svh
// assertion macros used by the checker file
`ifndef STRING_ESCAPE_DECODER_UTF8_ASSERT_SVH
`define STRING_ESCAPE_DECODER_UTF8_ASSERT_SVH

// same-cycle implication, off during reset
`define SED_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("string escape decoder check failed");

// next-cycle implication, off during reset
`define SED_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("string escape decoder check failed");

`endif

// File: hw/rtl/sed_pkg.sv
`default_nettype none

package sed_pkg;

    // job queue depth between parser and serializer
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // character codes
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_N      = 8'h6e;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_LBRACE = 8'h7b;
    localparam logic [7:0] CH_RBRACE = 8'h7d;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_TAB    = 8'h09;

    // code point limits
    localparam logic [20:0] CP_MAX_1B  = 21'h00007f;
    localparam logic [20:0] CP_MAX_2B  = 21'h0007ff;
    localparam logic [20:0] CP_SUR_LO  = 21'h00d800;
    localparam logic [20:0] CP_SUR_HI  = 21'h00dfff;
    localparam logic [20:0] CP_MAX_3B  = 21'h00ffff;
    localparam logic [20:0] CP_MAX     = 21'h10ffff;

    typedef enum logic [2:0] {
        PH_NORMAL  = 3'd0,
        PH_ESC     = 3'd1,
        PH_X1      = 3'd2,
        PH_X2      = 3'd3,
        PH_UOPEN   = 3'd4,
        PH_UFIRST  = 3'd5,
        PH_UDIG    = 3'd6,
        PH_DISCARD = 3'd7
    } t_phase;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
        logic       error;
    } t_out_item;

    // one decoded input byte: up to four result bytes
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      last_idx;
        logic            last;
        logic            err;
    } t_job;

    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      n;
    } t_enc;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_nib;

    function automatic t_nib hex_nibble(input logic [7:0] c);
        t_nib r;
        r = '0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r.ok  = 1'b1;
            r.val = 4'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r.ok  = 1'b1;
            r.val = 4'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r.ok  = 1'b1;
            r.val = 4'(c - 8'h37);
        end
        return r;
    endfunction

    // utf-8 encode, n is zero for surrogates and out-of-range values
    function automatic t_enc utf8_encode(input logic [20:0] cp);
        t_enc r;
        r = '0;
        if (cp <= CP_MAX_1B) begin
            r.bytes[0] = cp[7:0];
            r.n        = 3'd1;
        end else if (cp <= CP_MAX_2B) begin
            r.bytes[0] = {3'b110, cp[10:6]};
            r.bytes[1] = {2'b10, cp[5:0]};
            r.n        = 3'd2;
        end else if (cp >= CP_SUR_LO && cp <= CP_SUR_HI) begin
            r.n = 3'd0;
        end else if (cp <= CP_MAX_3B) begin
            r.bytes[0] = {4'b1110, cp[15:12]};
            r.bytes[1] = {2'b10, cp[11:6]};
            r.bytes[2] = {2'b10, cp[5:0]};
            r.n        = 3'd3;
        end else if (cp <= CP_MAX) begin
            r.bytes[0] = {5'b11110, cp[20:18]};
            r.bytes[1] = {2'b10, cp[17:12]};
            r.bytes[2] = {2'b10, cp[11:6]};
            r.bytes[3] = {2'b10, cp[5:0]};
            r.n        = 3'd4;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/sed_front.sv
`default_nettype none

module sed_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire sed_pkg::t_in_item i_in,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic              i_cfg_data,
    input  wire logic              i_q_full,
    output logic                   o_q_push,
    output sed_pkg::t_job          o_q_job
);

    sed_pkg::t_phase r_phase, n_phase;
    logic [3:0]      r_nib, n_nib;
    logic [20:0]     r_acc, n_acc;
    logic            r_hex_cp;

    logic            accept;
    logic            bad;
    sed_pkg::t_enc   enc;
    sed_pkg::t_nib   nib;
    sed_pkg::t_enc   enc_in;
    logic [20:0]     enc_cp;
    logic            enc_use;
    logic [24:0]     acc_next;
    sed_pkg::t_phase ph_after;
    logic            err;

    assign o_in_stall  = i_q_full;
    assign o_cfg_ready = 1'b1;
    assign accept      = i_in_valid && !i_q_full;

    assign nib      = sed_pkg::hex_nibble(i_in.in_byte);
    assign acc_next = {r_acc, 4'h0} | {21'h0, nib.val};

    // code point to encode: \xHH value or the collected \u value
    assign enc_cp   = (r_phase == sed_pkg::PH_X2) ? {13'h0, r_nib, nib.val} : r_acc;
    assign enc_in   = sed_pkg::utf8_encode(enc_cp);

    // parse one byte
    always_comb begin
        n_phase = r_phase;
        n_nib   = r_nib;
        n_acc   = r_acc;
        bad     = 1'b0;
        enc     = '0;
        enc_use = 1'b0;
        unique case (r_phase)
            sed_pkg::PH_NORMAL: begin
                if (i_in.in_byte == sed_pkg::CH_BSLASH) begin
                    n_phase = sed_pkg::PH_ESC;
                end else begin
                    enc.bytes[0] = i_in.in_byte;
                    enc.n        = 3'd1;
                end
            end
            sed_pkg::PH_ESC: begin
                n_phase = sed_pkg::PH_NORMAL;
                priority if (i_in.in_byte == sed_pkg::CH_N) begin
                    enc.bytes[0] = sed_pkg::CH_LF;
                    enc.n        = 3'd1;
                end else if (i_in.in_byte == sed_pkg::CH_R) begin
                    enc.bytes[0] = sed_pkg::CH_CR;
                    enc.n        = 3'd1;
                end else if (i_in.in_byte == sed_pkg::CH_T) begin
                    enc.bytes[0] = sed_pkg::CH_TAB;
                    enc.n        = 3'd1;
                end else if (i_in.in_byte == sed_pkg::CH_BSLASH
                          || i_in.in_byte == sed_pkg::CH_SQUOTE
                          || i_in.in_byte == sed_pkg::CH_DQUOTE) begin
                    enc.bytes[0] = i_in.in_byte;
                    enc.n        = 3'd1;
                end else if (i_in.in_byte == sed_pkg::CH_X) begin
                    n_phase = sed_pkg::PH_X1;
                end else if (i_in.in_byte == sed_pkg::CH_U) begin
                    n_phase = sed_pkg::PH_UOPEN;
                end else begin
                    bad = 1'b1;
                end
            end
            sed_pkg::PH_X1: begin
                if (!nib.ok) begin
                    bad = 1'b1;
                end else begin
                    n_nib   = nib.val;
                    n_phase = sed_pkg::PH_X2;
                end
            end
            sed_pkg::PH_X2: begin
                if (!nib.ok) begin
                    bad = 1'b1;
                end else if (!r_hex_cp) begin
                    enc.bytes[0] = {r_nib, nib.val};
                    enc.n        = 3'd1;
                    n_phase      = sed_pkg::PH_NORMAL;
                end else begin
                    enc_use = 1'b1;
                    n_phase = sed_pkg::PH_NORMAL;
                end
            end
            sed_pkg::PH_UOPEN: begin
                if (i_in.in_byte == sed_pkg::CH_LBRACE) begin
                    n_acc   = '0;
                    n_phase = sed_pkg::PH_UFIRST;
                end else begin
                    bad = 1'b1;
                end
            end
            sed_pkg::PH_UFIRST: begin
                if (!nib.ok) begin
                    bad = 1'b1;
                end else begin
                    n_acc   = {17'h0, nib.val};
                    n_phase = sed_pkg::PH_UDIG;
                end
            end
            sed_pkg::PH_UDIG: begin
                if (i_in.in_byte == sed_pkg::CH_RBRACE) begin
                    enc_use = 1'b1;
                    if (enc_in.n == 3'd0) begin
                        bad = 1'b1;
                    end else begin
                        n_phase = sed_pkg::PH_NORMAL;
                    end
                end else if (!nib.ok) begin
                    bad = 1'b1;
                end else if (acc_next > {4'h0, sed_pkg::CP_MAX}) begin
                    bad = 1'b1;
                end else begin
                    n_acc = acc_next[20:0];
                end
            end
            sed_pkg::PH_DISCARD: begin
                n_phase = sed_pkg::PH_DISCARD;
            end
            default: begin
                n_phase = sed_pkg::PH_DISCARD;
            end
        endcase

        if (enc_use) begin
            enc = enc_in;
        end
        if (bad) begin
            n_phase = sed_pkg::PH_DISCARD;
            enc     = '0;
        end
        ph_after = n_phase;

        // end of string returns to the start state
        if (i_in.in_last) begin
            n_phase = sed_pkg::PH_NORMAL;
            n_nib   = '0;
            n_acc   = '0;
        end
    end

    // job for the serializer
    always_comb begin
        err       = i_in.in_last && (ph_after != sed_pkg::PH_NORMAL || enc.n == 3'd0);
        o_q_push  = accept && (enc.n != 3'd0 || i_in.in_last);
        o_q_job   = '0;
        o_q_job.last = i_in.in_last;
        o_q_job.err  = err;
        if (!err) begin
            o_q_job.bytes    = enc.bytes;
            o_q_job.last_idx = 2'(enc.n - 3'd1);
        end
    end

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= sed_pkg::PH_NORMAL;
            r_nib   <= '0;
            r_acc   <= '0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_nib   <= n_nib;
            r_acc   <= n_acc;
        end
    end

    // mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hex_cp <= 1'b0;
        end else if (i_cfg_valid) begin
            r_hex_cp <= i_cfg_data;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/sed_queue.sv
`default_nettype none

module sed_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire sed_pkg::t_job i_job,
    output logic               o_full,
    input  wire logic          i_pop,
    output logic               o_empty,
    output sed_pkg::t_job      o_head
);

    sed_pkg::t_job                    r_mem [sed_pkg::QDEPTH];
    logic [sed_pkg::QPTR_W-1:0]       r_wptr;
    logic [sed_pkg::QPTR_W-1:0]       r_rptr;
    logic [sed_pkg::QCNT_W-1:0]       r_cnt;

    assign o_full  = (r_cnt == sed_pkg::QCNT_W'(sed_pkg::QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rptr];

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/sed_back.sv
`default_nettype none

module sed_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_q_empty,
    input  wire sed_pkg::t_job i_q_head,
    output logic               o_q_pop,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output sed_pkg::t_out_item o_out
);

    logic [1:0]         r_idx;
    logic               r_ovalid;
    sed_pkg::t_out_item r_out;
    logic               load;
    logic               at_end;

    assign load        = !i_q_empty && (!r_ovalid || !i_out_stall);
    assign at_end      = (r_idx == i_q_head.last_idx);
    assign o_q_pop     = load && at_end;
    assign o_out_valid = r_ovalid;
    assign o_out       = r_out;

    // byte index within the head job
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (load) begin
                r_idx <= at_end ? 2'd0 : r_idx + 2'd1;
            end
            if (load) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // output beat register
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out.out_byte <= i_q_head.bytes[r_idx];
            r_out.out_last <= i_q_head.last && at_end;
            r_out.error    <= i_q_head.err;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/string_escape_decoder_utf8.sv
// channel  | direction | handshake               | beat
// ---------+-----------+-------------------------+------------------------------
// in       | input     | i_in_valid / o_in_stall | t_in_item: in_byte, in_last
// out      | output    | o_out_valid / i_out_stall | t_out_item: out_byte, out_last, error
// cfg      | input     | i_cfg_valid / o_cfg_ready | i_cfg_data: hex_as_codepoint
//
// one input byte accepted per cycle unless the job queue is full; the parser hands
// a job of 1 to 4 bytes to a 4-entry queue, and the serializer sends one output
// beat per cycle unless i_out_stall holds it, so an escape expanding to k bytes
// takes k beats; each job goes through the queue, then the output beat register.
// synchronous active-low reset clears parser state, queue pointers and output valid.
// o_in_stall rises only while the job queue is full; cfg is always ready.
`default_nettype none

module string_escape_decoder_utf8 (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire sed_pkg::t_in_item  i_in,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output sed_pkg::t_out_item      o_out,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic               i_cfg_data
);

    logic          q_push;
    logic          q_pop;
    logic          q_full;
    logic          q_empty;
    sed_pkg::t_job q_job;
    sed_pkg::t_job q_head;

    // parser
    sed_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_q_job     (q_job)
    );

    // job queue
    sed_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    // serializer
    sed_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_q_head    (q_head),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

// File: hw/rtl/sed_checker.sv
`default_nettype none
`include "string_escape_decoder_utf8_assert.svh"

module sed_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               o_out_valid,
    input wire logic               i_out_stall,
    input wire sed_pkg::t_out_item o_out
);

    // a stalled beat stays
    `SED_ASSERT_NEXT(a_out_hold_valid, o_out_valid && i_out_stall, o_out_valid)
    `SED_ASSERT_NEXT(a_out_hold_data, o_out_valid && i_out_stall, $stable(o_out))
    // an error beat closes the string
    `SED_ASSERT_NOW(a_err_is_last, o_out_valid && o_out.error, o_out.out_last)
    // an error beat carries a zero byte
    `SED_ASSERT_NOW(a_err_zero, o_out_valid && o_out.error, o_out.out_byte == 8'h00)

endmodule

bind string_escape_decoder_utf8 sed_checker u_sed_checker (.*);

`default_nettype wire

// File: sim/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import sed_pkg::*;

    localparam int CYCLE_LIMIT  = 100000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_BYTES  = 40;

    localparam logic [7:0] ASCII_0  = 8'h30;
    localparam logic [7:0] ASCII_UA = 8'h41;
    localparam logic [7:0] ASCII_LA = 8'h61;

    // ways a string can be malformed
    typedef enum int {
        BRK_LETTER,
        BRK_X_FIRST,
        BRK_X_SECOND,
        BRK_NO_BRACE,
        BRK_EMPTY,
        BRK_TOO_BIG,
        BRK_SURROGATE,
        BRK_U_DIGIT,
        BRK_CUT
    } t_breakage;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    t_in_item   i_in        = '0;
    logic       i_out_stall = 1'b0;
    logic       i_cfg_valid = 1'b0;
    logic       i_cfg_data  = 1'b0;
    logic       o_in_stall;
    logic       o_out_valid;
    t_out_item  o_out;
    logic       o_cfg_ready;

    // stimulus and expected output beats
    t_in_item   serial_bytes[$];
    t_out_item  decoded_due[$];

    // decoder state as predicted
    t_phase     scan_phase = PH_NORMAL;
    logic [3:0] hi_nibble  = '0;
    logic [20:0] cp_acc    = '0;
    logic       hex_mode   = 1'b0;

    // traffic shaping knobs
    int         in_idle_pct    = 0;
    int         out_stall_pct  = 0;
    int         out_hold_left  = 0;
    bit         in_taken       = 1'b0;

    int         cycles         = 0;
    int         fail_count     = 0;
    int         bytes_in       = 0;
    int         beats_checked  = 0;
    int         strings_done   = 0;
    int         strings_bad    = 0;

    string_escape_decoder_utf8 DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
    end

    // ---------------------------------------------------------------- helpers

    function automatic int hex_value(input logic [7:0] c);
        if (c >= ASCII_0 && c <= ASCII_0 + 8'd9) return int'(c - ASCII_0);
        if (c >= ASCII_LA && c <= ASCII_LA + 8'd5) return int'(c - ASCII_LA) + 10;
        if (c >= ASCII_UA && c <= ASCII_UA + 8'd5) return int'(c - ASCII_UA) + 10;
        return -1;
    endfunction

    // utf-8 bytes of a code point, count zero when not encodable
    function automatic int utf8_bytes(input logic [20:0] cp, output logic [3:0][7:0] seq);
        int n;
        seq = '0;
        if ((cp >= CP_SUR_LO && cp <= CP_SUR_HI) || cp > CP_MAX) return 0;
        if (cp <= CP_MAX_1B) begin
            seq[0] = cp[7:0];
            return 1;
        end
        n = (cp <= CP_MAX_2B) ? 2 : (cp <= CP_MAX_3B) ? 3 : 4;
        for (int k = n - 1; k >= 1; k--) begin
            seq[k] = {2'b10, 6'(cp >> (6 * (n - 1 - k)))};
        end
        seq[0] = 8'(8'hff << (8 - n)) | 8'(cp >> (6 * (n - 1)));
        return n;
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        fail_count++;
    endtask

    // predicted output beats for one accepted input beat
    task automatic decode_byte(input t_in_item it);
        logic [3:0][7:0] seq;
        logic [24:0]     grown;
        t_out_item       beat;
        int              n;
        int              d;
        bit              bad;
        seq = '0;
        n   = 0;
        bad = 1'b0;
        d   = hex_value(it.in_byte);
        case (scan_phase)
            PH_NORMAL: begin
                if (it.in_byte == CH_BSLASH) begin
                    scan_phase = PH_ESC;
                end else begin
                    seq[0] = it.in_byte;
                    n = 1;
                end
            end
            PH_ESC: begin
                scan_phase = PH_NORMAL;
                case (it.in_byte)
                    CH_N: begin
                        seq[0] = CH_LF;
                        n = 1;
                    end
                    CH_R: begin
                        seq[0] = CH_CR;
                        n = 1;
                    end
                    CH_T: begin
                        seq[0] = CH_TAB;
                        n = 1;
                    end
                    CH_BSLASH, CH_SQUOTE, CH_DQUOTE: begin
                        seq[0] = it.in_byte;
                        n = 1;
                    end
                    CH_X: scan_phase = PH_X1;
                    CH_U: scan_phase = PH_UOPEN;
                    default: bad = 1'b1;
                endcase
            end
            PH_X1: begin
                if (d < 0) begin
                    bad = 1'b1;
                end else begin
                    hi_nibble  = 4'(d);
                    scan_phase = PH_X2;
                end
            end
            PH_X2: begin
                if (d < 0) begin
                    bad = 1'b1;
                end else if (!hex_mode) begin
                    seq[0] = {hi_nibble, 4'(d)};
                    n = 1;
                    scan_phase = PH_NORMAL;
                end else begin
                    n = utf8_bytes({13'd0, hi_nibble, 4'(d)}, seq);
                    scan_phase = PH_NORMAL;
                end
            end
            PH_UOPEN: begin
                if (it.in_byte == CH_LBRACE) begin
                    cp_acc     = '0;
                    scan_phase = PH_UFIRST;
                end else begin
                    bad = 1'b1;
                end
            end
            PH_UFIRST: begin
                if (d < 0) begin
                    bad = 1'b1;
                end else begin
                    cp_acc     = 21'(d);
                    scan_phase = PH_UDIG;
                end
            end
            PH_UDIG: begin
                if (it.in_byte == CH_RBRACE) begin
                    n = utf8_bytes(cp_acc, seq);
                    if (n == 0) bad = 1'b1;
                    else scan_phase = PH_NORMAL;
                end else if (d < 0) begin
                    bad = 1'b1;
                end else begin
                    grown = {cp_acc, 4'(d)};
                    if (grown > 25'(CP_MAX)) bad = 1'b1;
                    else cp_acc = grown[20:0];
                end
            end
            default: ;
        endcase

        if (bad) begin
            scan_phase = PH_DISCARD;
            n = 0;
        end

        // final byte: full sequence or a single error beat
        if (it.in_last && (scan_phase != PH_NORMAL || n == 0)) begin
            beat = '{out_byte: 8'h00, out_last: 1'b1, error: 1'b1};
            decoded_due.push_back(beat);
        end else begin
            for (int k = 0; k < n; k++) begin
                beat = '{out_byte: seq[k], out_last: it.in_last && k == n - 1, error: 1'b0};
                decoded_due.push_back(beat);
            end
        end

        if (it.in_last) begin
            scan_phase = PH_NORMAL;
            hi_nibble  = '0;
            cp_acc     = '0;
        end
    endtask

    task automatic check_result(input t_out_item got);
        t_out_item want;
        if (decoded_due.size() == 0) begin
            report_mismatch($sformatf("unexpected beat byte=%02h last=%0b err=%0b",
                                      got.out_byte, got.out_last, got.error));
            return;
        end
        want = decoded_due.pop_front();
        beats_checked++;
        if (want.out_last) strings_done++;
        if (want.error) strings_bad++;
        if (got.out_byte !== want.out_byte)
            report_mismatch($sformatf("out_byte %02h, expected %02h",
                                      got.out_byte, want.out_byte));
        if (got.out_last !== want.out_last)
            report_mismatch($sformatf("out_last %0b, expected %0b",
                                      got.out_last, want.out_last));
        if (got.error !== want.error)
            report_mismatch($sformatf("error %0b, expected %0b", got.error, want.error));
    endtask

    // ---------------------------------------------------------------- stimulus

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 4'd10) return ASCII_0 + 8'(v);
        return ($urandom_range(1) ? ASCII_UA : ASCII_LA) + 8'(v) - 8'd10;
    endfunction

    function automatic logic [7:0] non_hex_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(255));
        while (hex_value(b) >= 0 || b == CH_RBRACE);
        return b;
    endfunction

    function automatic logic [23:0] pick_codepoint();
        logic [23:0] cp_corners[10] = '{24'h0, 24'h7f, 24'h80, 24'h7ff, 24'h800,
                                        24'hd7ff, 24'he000, 24'hffff, 24'h10000, 24'h10ffff};
        case ($urandom_range(6))
            0: return 24'($urandom_range(24'h0, 24'h7f));
            1: return 24'($urandom_range(24'h80, 24'h7ff));
            2: return 24'($urandom_range(24'h800, 24'hd7ff));
            3: return 24'($urandom_range(24'he000, 24'hffff));
            4: return 24'($urandom_range(24'h10000, 24'h10ffff));
            default: return cp_corners[$urandom_range(9)];
        endcase
    endfunction

    task automatic append_digits(ref logic [7:0] text[$], input logic [23:0] cp);
        int ndig;
        int zeros;
        ndig  = 1;
        zeros = ($urandom_range(3) == 0) ? $urandom_range(1, 8) : 0;
        while (ndig < 6 && (cp >> (4 * ndig)) != 0) ndig++;
        repeat (zeros) text.push_back(ASCII_0);
        for (int k = ndig - 1; k >= 0; k--) text.push_back(hex_char(4'(cp >> (4 * k))));
    endtask

    task automatic append_x_escape(ref logic [7:0] text[$]);
        text.push_back(CH_BSLASH);
        text.push_back(CH_X);
        text.push_back(hex_char(4'($urandom_range(15))));
        text.push_back(hex_char(4'($urandom_range(15))));
    endtask

    task automatic append_u_escape(ref logic [7:0] text[$], input logic [23:0] cp);
        text.push_back(CH_BSLASH);
        text.push_back(CH_U);
        text.push_back(CH_LBRACE);
        append_digits(text, cp);
        text.push_back(CH_RBRACE);
    endtask

    // one well-formed element: plain byte or escape
    task automatic append_element(ref logic [7:0] text[$]);
        logic [7:0] b;
        case ($urandom_range(5))
            0, 1: begin
                do b = 8'($urandom_range(255));
                while (b == CH_BSLASH);
                text.push_back(b);
            end
            2: begin
                text.push_back(CH_BSLASH);
                case ($urandom_range(5))
                    0: text.push_back(CH_N);
                    1: text.push_back(CH_R);
                    2: text.push_back(CH_T);
                    3: text.push_back(CH_BSLASH);
                    4: text.push_back(CH_SQUOTE);
                    default: text.push_back(CH_DQUOTE);
                endcase
            end
            3: append_x_escape(text);
            default: append_u_escape(text, pick_codepoint());
        endcase
    endtask

    // one malformed element, then some bytes the decoder should swallow
    task automatic append_broken(ref logic [7:0] text[$], input t_breakage kind);
        logic [7:0] tmp[$];
        logic [7:0] b;
        int         keep;
        case (kind)
            BRK_LETTER: begin
                text.push_back(CH_BSLASH);
                do b = 8'($urandom_range(255));
                while (b inside {CH_N, CH_R, CH_T, CH_BSLASH, CH_SQUOTE, CH_DQUOTE, CH_X, CH_U});
                text.push_back(b);
            end
            BRK_X_FIRST: begin
                text.push_back(CH_BSLASH);
                text.push_back(CH_X);
                text.push_back(non_hex_byte());
            end
            BRK_X_SECOND: begin
                text.push_back(CH_BSLASH);
                text.push_back(CH_X);
                text.push_back(hex_char(4'($urandom_range(15))));
                text.push_back(non_hex_byte());
            end
            BRK_NO_BRACE: begin
                text.push_back(CH_BSLASH);
                text.push_back(CH_U);
                do b = 8'($urandom_range(255));
                while (b == CH_LBRACE);
                text.push_back(b);
            end
            BRK_EMPTY: begin
                text.push_back(CH_BSLASH);
                text.push_back(CH_U);
                text.push_back(CH_LBRACE);
                text.push_back(CH_RBRACE);
            end
            BRK_TOO_BIG: append_u_escape(text, 24'($urandom_range(24'h110000, 24'hffffff)));
            BRK_SURROGATE: append_u_escape(text, 24'($urandom_range(24'hd800, 24'hdfff)));
            BRK_U_DIGIT: begin
                text.push_back(CH_BSLASH);
                text.push_back(CH_U);
                text.push_back(CH_LBRACE);
                repeat ($urandom_range(2)) text.push_back(hex_char(4'($urandom_range(15))));
                text.push_back(non_hex_byte());
            end
            default: begin
                // escape cut short by the end of the string
                if ($urandom_range(1)) append_x_escape(tmp);
                else append_u_escape(tmp, pick_codepoint());
                keep = $urandom_range(1, tmp.size() - 1);
                for (int k = 0; k < keep; k++) text.push_back(tmp[k]);
            end
        endcase
        if (kind != BRK_CUT) begin
            repeat ($urandom_range(3)) text.push_back(8'($urandom_range(255)));
        end
    endtask

    task automatic queue_text(ref logic [7:0] text[$]);
        t_in_item it;
        foreach (text[k]) begin
            it.in_byte = text[k];
            it.in_last = (k == text.size() - 1);
            serial_bytes.push_back(it);
        end
    endtask

    task automatic queue_string(input string s);
        logic [7:0] text[$];
        for (int k = 0; k < s.len(); k++) text.push_back(s[k]);
        queue_text(text);
    endtask

    task automatic add_random_string(output int count);
        logic [7:0] text[$];
        t_breakage  kind;
        int         elems;
        int         broken_at;
        elems     = $urandom_range(1, 5);
        broken_at = ($urandom_range(99) < 22) ? $urandom_range(0, elems - 1) : -1;
        for (int e = 0; e < elems; e++) begin
            if (e == broken_at) begin
                kind = t_breakage'($urandom_range(8));
                append_broken(text, kind);
                if (kind == BRK_CUT) break;
            end else begin
                append_element(text);
            end
        end
        queue_text(text);
        count = text.size();
    endtask

    task automatic wait_idle();
        do @(posedge i_clk);
        while (serial_bytes.size() != 0 || i_in_valid || decoded_due.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_mode(input logic value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // ---------------------------------------------------------------- driver and monitor

    // input beats, held while stalled
    always @(negedge i_clk) begin
        if (!i_in_valid || in_taken) begin
            if (serial_bytes.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
                i_in       <= serial_bytes.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // output stall, with an optional long hold
    always @(negedge i_clk) begin
        if (out_hold_left > 0) begin
            i_out_stall   <= 1'b1;
            out_hold_left <= out_hold_left - 1;
        end else begin
            i_out_stall <= ($urandom_range(99) < out_stall_pct);
        end
    end

    // check output beats, track config, predict from accepted input beats
    always @(posedge i_clk) begin
        in_taken = 1'b0;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) check_result(o_out);
            if (i_cfg_valid && o_cfg_ready) hex_mode = i_cfg_data;
            if (i_in_valid && !o_in_stall) begin
                in_taken = 1'b1;
                bytes_in++;
                decode_byte(i_in);
            end
        end
    end

    // watchdog
    initial begin
        wait (cycles >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d beats still expected",
                 cycles, decoded_due.size());
        $display("testbench failed");
        $finish;
    end

    // ---------------------------------------------------------------- sequence

    initial begin
        int idle_mix[4][2] = '{'{0, 0}, '{50, 0}, '{0, 50}, '{14, 14}};
        int phase_bytes;
        int added;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed strings, raw \x mode out of reset
        serial_bytes.push_back('{in_byte: 8'h00, in_last: 1'b0});
        serial_bytes.push_back('{in_byte: 8'hff, in_last: 1'b1});
        queue_string("\\xFf");
        queue_string("\\u{10fFFf}");
        queue_string("\\q");
        queue_string("\\u{");
        queue_string("\\");
        queue_string("\\\"");
        wait_idle();

        // random strings under each idle/stall mix, alternating \x mode
        for (int p = 0; p < 4; p++) begin
            write_mode(p % 2 == 0);
            in_idle_pct   = idle_mix[p][0];
            out_stall_pct = idle_mix[p][1];
            if (p == 0) out_hold_left = 48;
            phase_bytes = 0;
            while (phase_bytes < PHASE_BYTES) begin
                add_random_string(added);
                phase_bytes += added;
            end
            wait_idle();
        end

        $display("covered %0d input bytes, %0d strings (%0d malformed), %0d beats checked",
                 bytes_in, strings_done, strings_bad, beats_checked);
        $display("both \\x modes, long output hold, sender and receiver idle mixes");
        if (fail_count == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
